/* hw/rtl/multi_channel_timer_table_core_macros.svh */
// Assertion macros for the timer table checker
`ifndef MULTI_CHANNEL_TIMER_TABLE_CORE_MACROS_SVH
`define MULTI_CHANNEL_TIMER_TABLE_CORE_MACROS_SVH
// check that an implication holds at every clock, off in reset
`define MCT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// same, with reset ignored
`define MCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hw/rtl/mctt_pkg.sv */
// Package: mode codes and constants for the timer table
package mctt_pkg;
  typedef enum logic [3:0] {
    MODE_CREATE = 4'd0, MODE_START = 4'd1, MODE_STOP = 4'd2, MODE_CHECK = 4'd3,
    MODE_GSTOP = 4'd4, MODE_OSTOP = 4'd5, MODE_CLEAR = 4'd6, MODE_NEXT = 4'd7,
    MODE_TICK = 4'd8
  } mode_e;
  localparam int unsigned MAX_EVENTS = 16;
  localparam logic [62:0] TIME_MAX = {63{1'b1}};
  localparam logic [62:0] IDLE_WAIT_NS = 63'd60_000_000_000;
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_SCAN = 5'b00010, ST_FREE = 5'b00100,
    ST_EMIT = 5'b01000, ST_DONE = 5'b10000
  } state_e;
  // saturating 63-bit add
  function automatic logic [62:0] sat_add(logic [62:0] a, logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? TIME_MAX : s[62:0];
  endfunction
endpackage

/* hw/rtl/multi_channel_timer_table_core.sv */
// Top level: timer channel table, one slot visited per cycle
// Results are registered: the closing result comes after the slot scan and, for a
// create with no match, a search for a free slot; a tick emits each event in the cycle after
// its slot is visited. A new command is accepted only while idle (busy low);
// busy is high through the closing result, strobed by valid_o; the receiver cannot stall.
// Reset clears all slot state at once (table is held in flip-flops).
module multi_channel_timer_table_core #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode_i,
  input  logic [7:0]  owner_i,
  input  logic [15:0] timer_id_i,
  input  logic [7:0]  group_tag_i,
  input  logic        repeat_req_i,
  input  logic [47:0] interval_ns_i,
  input  logic [31:0] user_word_a_i,
  input  logic [31:0] user_word_b_i,
  input  logic [31:0] expect_count_i,
  input  logic        notify_i,
  input  logic [62:0] now_ns_i,
  output logic        valid_o,
  output logic        status_o,
  output logic        fired_o,
  output logic [31:0] out_user_a_o,
  output logic [31:0] out_user_b_o,
  output logic [7:0]  out_group_o,
  output logic [15:0] out_timer_id_o,
  output logic [31:0] out_generation_o,
  output logic [62:0] deadline_ns_o,
  output logic        last_o
);
  import mctt_pkg::*;
  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [7:0]  owner_q [NUM_TIMERS];
  logic [15:0] id_q    [NUM_TIMERS];
  logic [7:0]  group_q [NUM_TIMERS];
  logic [47:0] intv_q  [NUM_TIMERS];
  logic [62:0] dl_q    [NUM_TIMERS];
  logic [31:0] gen_q   [NUM_TIMERS];
  logic [31:0] ua_q    [NUM_TIMERS];
  logic [31:0] ub_q    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rep_q, act_q, ntf_q;

  state_e      st_q;
  logic [IW-1:0] idx_q;
  logic [3:0]  mode_q;
  logic [7:0]  own_c_q, grp_c_q;
  logic [15:0] id_c_q;
  logic        rep_c_q, ntf_c_q;
  logic [47:0] intv_c_q;
  logic [31:0] ua_c_q, ub_c_q, exp_c_q;
  logic [62:0] now_c_q;
  logic        found_q, any_q, stat_q;
  logic [62:0] best_q;
  logic [4:0]  nev_q;

  logic [IW-1:0] i;
  logic        match, last_idx, fire;
  logic [62:0] slot_sum;
  assign i        = idx_q;
  assign match    = (id_q[i] == id_c_q) && (owner_q[i] == own_c_q) && (id_c_q != '0);
  assign last_idx = (idx_q == IW'(NUM_TIMERS - 1));
  assign slot_sum = sat_add(now_c_q, {15'd0, intv_q[i]});
  assign fire     = act_q[i] && (dl_q[i] < now_c_q);
  assign busy     = (st_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; idx_q <= '0; found_q <= 1'b0; any_q <= 1'b0; stat_q <= 1'b0;
      nev_q <= '0; valid_o <= 1'b0;
      rep_q <= '0; act_q <= '0; ntf_q <= '0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        owner_q[k] <= '0; id_q[k] <= '0; group_q[k] <= '0; intv_q[k] <= '0;
        dl_q[k] <= '0; gen_q[k] <= '0; ua_q[k] <= '0; ub_q[k] <= '0;
      end
    end else begin
      valid_o <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (start) begin
            mode_q <= mode_i; own_c_q <= owner_i; id_c_q <= timer_id_i;
            grp_c_q <= group_tag_i; rep_c_q <= repeat_req_i; intv_c_q <= interval_ns_i;
            ua_c_q <= user_word_a_i; ub_c_q <= user_word_b_i; exp_c_q <= expect_count_i;
            ntf_c_q <= notify_i; now_c_q <= now_ns_i;
            idx_q <= '0; found_q <= 1'b0; any_q <= 1'b0; nev_q <= '0;
            best_q <= '0; stat_q <= 1'b0;
            st_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          case (mode_q)
            MODE_CREATE, MODE_START, MODE_STOP, MODE_CHECK: begin
              if (match && !found_q) begin
                found_q <= 1'b1;
                case (mode_q)
                  MODE_CREATE: begin
                    group_q[i] <= grp_c_q; ua_q[i] <= ua_c_q; ub_q[i] <= ub_c_q;
                    rep_q[i] <= rep_c_q; act_q[i] <= 1'b0; intv_q[i] <= intv_c_q;
                    dl_q[i] <= '0;
                  end
                  MODE_START: begin dl_q[i] <= slot_sum; act_q[i] <= 1'b1; end
                  MODE_STOP: begin act_q[i] <= 1'b0; gen_q[i] <= gen_q[i] + 32'd1; end
                  default: stat_q <= (gen_q[i] != exp_c_q);
                endcase
              end
            end
            MODE_GSTOP, MODE_OSTOP: begin
              if (id_q[i] != '0 && owner_q[i] == own_c_q &&
                  (mode_q == MODE_OSTOP || group_q[i] == grp_c_q)) begin
                act_q[i] <= 1'b0; gen_q[i] <= gen_q[i] + 32'd1;
              end
            end
            MODE_CLEAR: begin
              id_q[i] <= '0; act_q[i] <= 1'b0; gen_q[i] <= gen_q[i] + 32'd1;
            end
            MODE_NEXT: begin
              if (act_q[i] && (!any_q || dl_q[i] < best_q)) begin
                best_q <= dl_q[i]; any_q <= 1'b1;
              end
            end
            MODE_TICK: begin
              if (fire) begin
                if (rep_q[i]) dl_q[i] <= slot_sum;
                else act_q[i] <= 1'b0;
                if (ntf_q[i] && nev_q < 5'(MAX_EVENTS)) begin
                  nev_q <= nev_q + 5'd1;
                  valid_o <= 1'b1; status_o <= 1'b0; fired_o <= 1'b1;
                  out_user_a_o <= ua_q[i]; out_user_b_o <= ub_q[i];
                  out_group_o <= group_q[i]; out_timer_id_o <= id_q[i];
                  out_generation_o <= gen_q[i]; deadline_ns_o <= '0; last_o <= 1'b0;
                end
              end
            end
            default: stat_q <= 1'b1;
          endcase
          if (last_idx || mode_q > MODE_TICK) begin
            idx_q <= '0;
            st_q <= ST_DONE;
            if (mode_q == MODE_CREATE) begin
              if (id_c_q == '0) stat_q <= 1'b1;
              else if (!(found_q || match)) st_q <= ST_FREE;
            end
            if (mode_q == MODE_CHECK && !(found_q || match)) stat_q <= 1'b1;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        ST_FREE: begin
          if (id_q[i] == '0) begin
            owner_q[i] <= own_c_q; id_q[i] <= id_c_q; ntf_q[i] <= ntf_c_q;
            group_q[i] <= grp_c_q; ua_q[i] <= ua_c_q; ub_q[i] <= ub_c_q;
            rep_q[i] <= rep_c_q; act_q[i] <= 1'b0; intv_q[i] <= intv_c_q;
            dl_q[i] <= '0;
            st_q <= ST_DONE;
          end else if (last_idx) begin
            stat_q <= 1'b1; st_q <= ST_DONE;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        ST_DONE: begin
          valid_o <= 1'b1; status_o <= stat_q; fired_o <= 1'b0;
          out_user_a_o <= '0; out_user_b_o <= '0; out_group_o <= '0;
          out_timer_id_o <= '0; out_generation_o <= '0; last_o <= 1'b1;
          deadline_ns_o <= (mode_q == MODE_NEXT) ?
                           (any_q ? best_q : sat_add(now_c_q, IDLE_WAIT_NS)) : '0;
          st_q <= ST_EMIT;
        end
        ST_EMIT: st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/mctt_checker.sv */
// Port-level checker for the timer table, bound to the top level
`include "multi_channel_timer_table_core_macros.svh"
module mctt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input logic fired_o,
  input logic last_o,
  input logic status_o
);
  `MCT_ASSERT(a_busy_after_start, clk_i, rst_ni, (start && !busy) |=> busy, "start not taken")
  `MCT_ASSERT(a_fired_not_last, clk_i, rst_ni, (valid_o && fired_o) |-> (!last_o && !status_o), "event marked last")
  `MCT_ASSERT(a_idle_after_last, clk_i, rst_ni, (valid_o && last_o) |=> !busy, "busy after closing transaction")
  `MCT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !valid_o, "result during reset")
endmodule

bind multi_channel_timer_table_core mctt_checker u_mctt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .valid_o(valid_o),
  .fired_o(fired_o), .last_o(last_o), .status_o(status_o)
);
